// File: src/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg: shared types and tables for the aes block cipher unit
// payload structs, sequencer states, register indexes and byte substitution
// ----------------------------------------------------------------------------
package aes_pkg;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aes_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_ROUND,
    ST_DONE
  } aes_state_t;

  localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] REG_KEY_0      = 3'd1;
  localparam logic [2:0] REG_KEY_1      = 3'd2;
  localparam logic [2:0] REG_KEY_2      = 3'd3;
  localparam logic [2:0] REG_KEY_3      = 3'd4;

  localparam logic [7:0] POLY_LOW = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? POLY_LOW : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// File: src/aes_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_unit: iterative aes-128/192/256 encrypt and decrypt
// one shared round unit plus a word-serial key expander under a sequencer
// ----------------------------------------------------------------------------
// usage
//   cfg_*  : apb-style register port; key_length at 0x00, key words at 0x08,
//            0x10, 0x18, 0x20 (64-bit data). write only while the unit is idle
//   in_*   : one beat carries kind (0 encrypt, 1 decrypt) and the 16 block
//            bytes; in_stall is high whenever an item is in flight
//   out_*  : one beat per input holding the result block, byte 0 at the top
// sequence
//   each item first expands all round keys one 32-bit word per cycle into a
//   local key memory (44, 52 or 60 words), then runs the initial key add and
//   nr rounds (10, 12, 14) on the shared round unit, each step being four
//   key word reads, a wait for the last read to land, then the round itself.
//   a new item is taken only once the previous result has been loaded into
//   the result register
// reset
//   synchronous active-low rst_n clears the config registers, out_valid and the sequencer
// back-pressure
//   the result register holds while out_stall is high; the next item may be
//   taken meanwhile, but it waits in the done step until the old beat is gone
// ----------------------------------------------------------------------------
module aes_block_cipher_unit
  import aes_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  aes_in_t       in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output aes_out_t      out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [5:0]    cfg_paddr,
  input  logic [63:0]   cfg_pwdata,
  output logic [63:0]   cfg_prdata,
  output logic          cfg_pready
);

  // configuration registers
  logic [1:0]  key_length_r;
  logic [63:0] key_r [4];
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= '0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KEY_LENGTH: key_length_r <= cfg_pwdata[1:0];
        REG_KEY_0:      key_r[0] <= cfg_pwdata;
        REG_KEY_1:      key_r[1] <= cfg_pwdata;
        REG_KEY_2:      key_r[2] <= cfg_pwdata;
        REG_KEY_3:      key_r[3] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_LENGTH: cfg_prdata = {62'd0, key_length_r};
      REG_KEY_0:      cfg_prdata = key_r[0];
      REG_KEY_1:      cfg_prdata = key_r[1];
      REG_KEY_2:      cfg_prdata = key_r[2];
      REG_KEY_3:      cfg_prdata = key_r[3];
      default:        cfg_prdata = '0;
    endcase
  end

  // key length decode; code 3 acts as 256-bit
  logic [3:0] nk;
  logic [3:0] nr;
  always_comb begin
    case (key_length_r)
      2'd0:    begin nk = 4'd4; nr = 4'd10; end
      2'd1:    begin nk = 4'd6; nr = 4'd12; end
      default: begin nk = 4'd8; nr = 4'd14; end
    endcase
  end
  logic [5:0] nwords;
  assign nwords = {nr, 2'b00} + 6'd4;

  // sequencer
  aes_state_t state_r, state_nxt;
  logic [5:0] wi_r, wi_nxt;       // key word index during expansion
  logic [3:0] rnd_r, rnd_nxt;     // rounds done
  logic       kind_r;
  logic [127:0] st_r;
  logic [31:0]  win_r [8];        // sliding window of last nk words
  logic [7:0]   rcon_r;
  logic [2:0]   kpos_r;           // i mod nk
  aes_out_t     out_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         load_out;

  logic in_acc, out_acc;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_acc   = out_valid_r && !out_stall;

  // result register loads once the previous beat is gone
  assign load_out      = (state_r == ST_DONE) && (!out_valid_r || out_acc);
  assign out_valid_nxt = load_out || (out_valid_r && !out_acc);

  // key memory: one write, one registered read
  logic [31:0] kmem [64];
  logic [127:0] rk_r;
  logic [31:0]  kw_wr;
  logic         kw_we;
  logic [5:0]   kw_addr;
  logic [5:0]   rd_word;
  logic [1:0]   rd_sub;
  logic [5:0]   rk_rnd_base;

  // next expanded word
  logic [31:0] tmp, prev, newword;
  logic        direct;
  always_comb begin
    direct = (wi_r < {2'd0, nk});
    prev   = win_r[nk[2:0] - 3'd1];
    tmp    = prev;
    if (kpos_r == 3'd0)
      tmp = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_r, 24'd0};
    else if (nk == 4'd8 && kpos_r == 3'd4)
      tmp = sub_word(prev);
    newword = win_r[0] ^ tmp;
    if (direct) begin
      case (wi_r[2:0])
        3'd0: newword = key_r[0][63:32];
        3'd1: newword = key_r[0][31:0];
        3'd2: newword = key_r[1][63:32];
        3'd3: newword = key_r[1][31:0];
        3'd4: newword = key_r[2][63:32];
        3'd5: newword = key_r[2][31:0];
        3'd6: newword = key_r[3][63:32];
        default: newword = key_r[3][31:0];
      endcase
    end
  end

  assign kw_we   = (state_r == ST_KEXP);
  assign kw_wr   = newword;
  assign kw_addr = wi_r;

  // round key fetch: the memory holds 32-bit words and a 128-bit round key is
  // gathered across four reads into rk_r; rd_sub walks the words
  logic [3:0] fetch_rnd;
  logic [1:0] sub_r, sub_nxt;
  logic [31:0] rd_data_r;
  logic        phase_r, phase_nxt; // 0 gather key, 1 apply round
  assign rd_sub      = sub_r;
  assign rk_rnd_base = {fetch_rnd, 2'b00};
  assign rd_word     = rk_rnd_base + {4'd0, rd_sub};

  always_ff @(posedge clk) begin
    if (kw_we) kmem[kw_addr] <= kw_wr;
    rd_data_r <= kmem[rd_word];
  end

  // round key index for the step at rnd_r
  always_comb begin
    if (kind_r) fetch_rnd = nr - rnd_r;
    else        fetch_rnd = rnd_r;
  end

  // shared round unit
  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] a2, a4, a8, p;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    p = 8'd0;
    if (m[0]) p = p ^ a;
    if (m[1]) p = p ^ a2;
    if (m[2]) p = p ^ a4;
    if (m[3]) p = p ^ a8;
    return p;
  endfunction

  logic [7:0] sb [16];
  logic [7:0] sh [16];
  logic [7:0] mx [16];
  logic [7:0] sin [16];
  logic [127:0] round_out;
  logic first, last;
  assign first = (rnd_r == 4'd0);
  assign last  = (rnd_r == nr);

  always_comb begin
    for (int i = 0; i < 16; i++) sin[i] = st_r[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (kind_r) sh[4*c+r] = INV_SBOX[sin[4*((c + 4 - r) & 3) + r]];
        else        sh[4*c+r] = SBOX[sin[4*((c + r) & 3) + r]];
    for (int i = 0; i < 16; i++) sb[i] = sh[i];
    // decrypt applies inverse mix after key add, so key is xored first here
    if (kind_r)
      for (int i = 0; i < 16; i++) sb[i] = sh[i] ^ rk_r[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (kind_r)
          mx[4*c+r] = gm(sb[4*c+((r)&3)], 4'he) ^ gm(sb[4*c+((r+1)&3)], 4'hb) ^
                      gm(sb[4*c+((r+2)&3)], 4'hd) ^ gm(sb[4*c+((r+3)&3)], 4'h9);
        else
          mx[4*c+r] = gm(sb[4*c+((r)&3)], 4'h2) ^ gm(sb[4*c+((r+1)&3)], 4'h3) ^
                      gm(sb[4*c+((r+2)&3)], 4'h1) ^ gm(sb[4*c+((r+3)&3)], 4'h1);
    for (int i = 0; i < 16; i++) begin
      if (first)
        round_out[127 - 8*i -: 8] = sin[i] ^ rk_r[127 - 8*i -: 8];
      else if (kind_r)
        round_out[127 - 8*i -: 8] = last ? sb[i] : mx[i];
      else
        round_out[127 - 8*i -: 8] = (last ? sb[i] : mx[i]) ^ rk_r[127 - 8*i -: 8];
    end
  end

  // gather: word k arrives the cycle after its address
  logic [1:0] gat_r;
  logic       gat_v_r;
  logic       flush_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_KEXP;
      ST_KEXP:  if (wi_r == nwords - 6'd1) state_nxt = ST_ROUND;
      ST_ROUND: if (phase_r && flush_r && last) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_acc) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    wi_nxt    = wi_r;
    rnd_nxt   = rnd_r;
    sub_nxt   = sub_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: begin
        wi_nxt = '0; rnd_nxt = '0; sub_nxt = '0; phase_nxt = 1'b0;
      end
      ST_KEXP: wi_nxt = wi_r + 6'd1;
      ST_ROUND: begin
        if (!phase_r) begin
          sub_nxt = sub_r + 2'd1;
          // read data arrives in the cycle after its address; the last word lands once phase goes high
          if (sub_r == 2'd3) phase_nxt = 1'b1;
        end else if (flush_r) begin
          phase_nxt = 1'b0;
          sub_nxt   = '0;
          rnd_nxt   = rnd_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wi_r        <= '0;
      rnd_r       <= '0;
      sub_r       <= '0;
      phase_r     <= 1'b0;
      gat_v_r     <= 1'b0;
      flush_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wi_r        <= wi_nxt;
      rnd_r       <= rnd_nxt;
      sub_r       <= sub_nxt;
      phase_r     <= phase_nxt;
      gat_v_r     <= (state_r == ST_ROUND) && !phase_r;
      // the last key word lands in rk_r in the cycle after phase goes high, so the round
      // is applied once flush_r is set
      flush_r     <= (state_r == ST_ROUND) && phase_r && !flush_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gat_r <= sub_r;
    if (gat_v_r) rk_r[127 - 32*gat_r -: 32] <= rd_data_r;
    if (in_acc) begin
      kind_r <= in_data.kind;
      st_r   <= {in_data.block_hi, in_data.block_lo};
    end
    if (state_r == ST_ROUND && phase_r && flush_r) st_r <= round_out;
    if (load_out) begin
      out_r.result_hi <= st_r[127:64];
      out_r.result_lo <= st_r[63:0];
    end
    // key window shift and rcon step
    if (state_r == ST_IDLE) begin
      kpos_r <= '0;
      rcon_r <= 8'h01;
    end else if (state_r == ST_KEXP) begin
      for (int i = 0; i < 7; i++)
        if (3'(i) != nk[2:0] - 3'd1) win_r[i] <= win_r[i + 1];
      win_r[nk[2:0] - 3'd1] <= newword;
      if (!direct) begin
        if (kpos_r == nk[2:0] - 3'd1) kpos_r <= '0;
        else                          kpos_r <= kpos_r + 3'd1;
        if (kpos_r == 3'd0) rcon_r <= xtime(rcon_r);
      end
    end
  end

endmodule
